FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: src/amt_pkg.sv
// Types and constants shared by the adaptive mean threshold modules.
`timescale 1ns / 1ps

package amt_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int WS_W       = 6;
    localparam int BIAS_W     = 9;
    localparam int DIM_W      = 9;

    localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

    localparam logic [WS_W-1:0]          RST_WINDOW_SIZE  = 6'd7;
    localparam logic signed [BIAS_W-1:0] RST_BIAS         = 9'sd5;
    localparam logic [DIM_W-1:0]         RST_FRAME_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]         RST_FRAME_HEIGHT = 9'd256;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pixel_in;
    } amt_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] binary_out;
        logic [PIX_W-1:0] threshold_out;
    } amt_result_t;

    typedef struct packed {
        logic wr;
        logic load_q;
        logic clamp;
        logic bound;
        logic rd_win;
        logic rd_cen;
        logic div_start;
        logic load_out;
    } amt_cmd_t;

    typedef struct packed {
        logic last;
        logic div_busy;
    } amt_status_t;

endpackage

FILE: src/adaptive_mean_threshold_core.sv
// Top level of the adaptive mean threshold block.
`timescale 1ns / 1ps

// A write item stores one pixel. A query item clamps the query point and the
// window setting, then bounds the window, clipped at the frame borders, and
// scans it: the window scan issues one frame store read per cycle on the
// single read port, and the mean comes from a restoring divider. One item is
// worked on at a time; a finished result waits in the output register while
// the next item is accepted.
module adaptive_mean_threshold_core import amt_pkg::*; #(
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 256,
    parameter int MAX_WINDOW = 63
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  amt_item_t             item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output amt_result_t           result,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    amt_cmd_t    cmd;
    amt_status_t status;

    amt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_command (item.command),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    amt_dp #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result)
    );

endmodule

FILE: src/amt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module amt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/amt_div.sv
// Restoring divider that yields a short quotient, one bit per cycle.
`timescale 1ns / 1ps

module amt_div #(
    parameter int SUMW = 20,
    parameter int CNTW = 12,
    parameter int QW   = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [SUMW-1:0] dividend,
    input  logic [CNTW-1:0] divisor,
    output logic [QW-1:0]   quotient,
    output logic            busy
);

    localparam int SW = $clog2(QW);

    logic [SUMW-1:0] rem_reg, rem_next;
    logic [SUMW-1:0] dsr_reg, dsr_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [SW-1:0]   step_reg, step_next;
    logic            busy_reg, busy_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = dividend;
            dsr_next  = SUMW'(divisor) << (QW - 1);
            q_next    = '0;
            step_next = SW'(QW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsr_reg)
            begin
                rem_next = rem_reg - dsr_reg;
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QW-2:0], 1'b0};
            end
            dsr_next = dsr_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg - SW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign quotient = q_reg;
    assign busy     = busy_reg;

endmodule

FILE: src/amt_ctrl.sv
// Controller state machine that sequences pixel writes and window queries.
`timescale 1ns / 1ps

module amt_ctrl import amt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_command,
    output logic        item_ready,
    output logic        result_valid,
    input  logic        result_ready,
    input  amt_status_t status,
    output amt_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CLAMP   = 3'd1;
    localparam logic [2:0] ST_BOUND   = 3'd2;
    localparam logic [2:0] ST_SCAN    = 3'd3;
    localparam logic [2:0] ST_CENTER  = 3'd4;
    localparam logic [2:0] ST_DIVGO   = 3'd5;
    localparam logic [2:0] ST_DIVWAIT = 3'd6;
    localparam logic [2:0] ST_RESULT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        item_ready     = 1'b0;
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_command == CMD_QUERY)
                    begin
                        cmd.load_q = 1'b1;
                        state_next = ST_CLAMP;
                    end
                    else
                    begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_BOUND;
            end
            ST_BOUND:
            begin
                cmd.bound  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.rd_win = 1'b1;
                if (status.last)
                begin
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                cmd.rd_cen = 1'b1;
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVWAIT;
            end
            ST_DIVWAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

FILE: src/amt_dp.sv
// Datapath: settings, frame store, window scan, accumulation, divide and compare.
`timescale 1ns / 1ps

module amt_dp import amt_pkg::*; #(
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 256,
    parameter int MAX_WINDOW = 63
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  amt_item_t             item,
    input  amt_cmd_t              cmd,
    output amt_status_t           status,
    output amt_result_t           result
);

    localparam int XW     = $clog2(MAX_COLS);
    localparam int YW     = $clog2(MAX_ROWS);
    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int AW     = $clog2(DEPTH);
    localparam int WSW_R  = $clog2(MAX_WINDOW + 1);
    localparam int WSW    = (WSW_R > WS_W) ? WSW_R : WS_W;
    localparam int M1     = (XW > YW) ? XW : YW;
    localparam int M2     = (M1 > WSW) ? M1 : WSW;
    localparam int M3     = (M2 > DIM_W) ? M2 : DIM_W;
    localparam int EW     = M3 + 2;
    localparam int SIDE   = 2 * (MAX_WINDOW / 2) + 1;
    localparam int CNTW   = $clog2(SIDE * SIDE + 1);
    localparam int SUMW   = CNTW + PIX_W;
    localparam int TW     = PIX_W + 3;

    logic [WS_W-1:0]          window_size_reg;
    logic signed [BIAS_W-1:0] bias_reg;
    logic [DIM_W-1:0]         frame_width_reg;
    logic [DIM_W-1:0]         frame_height_reg;

    logic [COORD_W-1:0] q_col_reg, q_row_reg;
    logic [XW-1:0]      cc_reg, wl_reg, x0_reg, x1_reg, c_reg;
    logic [YW-1:0]      rc_reg, hl_reg, y1_reg, r_reg;
    logic [WSW-1:0]     half_reg;
    logic [AW-1:0]      base_reg, cen_addr_reg;
    logic [SUMW-1:0]    sum_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic [PIX_W-1:0]   centre_reg;
    logic               acc_pend_reg, cen_pend_reg;
    amt_result_t        result_reg;

    logic [EW-1:0] fw_e, fh_e, w_eff, h_eff, wl_e, hl_e, cc_e, rc_e, ws_e, half_e;
    logic [EW-1:0] cc_b, rc_b, half_b, x0_e, y0_e, xs_e, ys_e, x1_e, y1_e;
    logic [AW-1:0] base_init, cen_addr, waddr, raddr;
    logic          wr_ok;
    logic [PIX_W-1:0] rdata, quot, thr;
    logic signed [TW-1:0] t_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= RST_WINDOW_SIZE;
            bias_reg         <= RST_BIAS;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE:  window_size_reg  <= cfg_data[WS_W-1:0];
                REG_BIAS:         bias_reg         <= $signed(cfg_data[BIAS_W-1:0]);
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                default:          window_size_reg  <= window_size_reg;
            endcase
        end
    end

    // Clamp the frame size, the query point and the window setting.
    always_comb
    begin
        fw_e   = EW'(frame_width_reg);
        fh_e   = EW'(frame_height_reg);
        w_eff  = (fw_e == '0) ? EW'(1) : ((fw_e > EW'(MAX_COLS)) ? EW'(MAX_COLS) : fw_e);
        h_eff  = (fh_e == '0) ? EW'(1) : ((fh_e > EW'(MAX_ROWS)) ? EW'(MAX_ROWS) : fh_e);
        wl_e   = w_eff - EW'(1);
        hl_e   = h_eff - EW'(1);
        cc_e   = (EW'(q_col_reg) > wl_e) ? wl_e : EW'(q_col_reg);
        rc_e   = (EW'(q_row_reg) > hl_e) ? hl_e : EW'(q_row_reg);
        ws_e   = (EW'(window_size_reg) > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW)
                                                          : EW'(window_size_reg);
        half_e = ws_e >> 1;
    end

    // Window bounds clipped at the frame borders.
    always_comb
    begin
        cc_b      = EW'(cc_reg);
        rc_b      = EW'(rc_reg);
        half_b    = EW'(half_reg);
        x0_e      = (cc_b > half_b) ? cc_b - half_b : '0;
        y0_e      = (rc_b > half_b) ? rc_b - half_b : '0;
        xs_e      = cc_b + half_b;
        ys_e      = rc_b + half_b;
        x1_e      = (xs_e > EW'(wl_reg)) ? EW'(wl_reg) : xs_e;
        y1_e      = (ys_e > EW'(hl_reg)) ? EW'(hl_reg) : ys_e;
        base_init = AW'(y0_e) * AW'(MAX_COLS);
        cen_addr  = AW'(rc_reg) * AW'(MAX_COLS) + AW'(cc_reg);
    end

    assign wr_ok  = (EW'(item.col) < EW'(MAX_COLS)) && (EW'(item.row) < EW'(MAX_ROWS));
    assign waddr  = AW'(item.row) * AW'(MAX_COLS) + AW'(item.col);
    assign raddr  = cmd.rd_cen ? cen_addr_reg : base_reg + AW'(c_reg);

    assign status.last = (c_reg == x1_reg) && (r_reg == y1_reg);

    amt_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (cmd.wr && wr_ok),
        .waddr (waddr),
        .wdata (item.pixel_in),
        .re    (cmd.rd_win || cmd.rd_cen),
        .raddr (raddr),
        .rdata (rdata)
    );

    amt_div #(
        .SUMW (SUMW),
        .CNTW (CNTW),
        .QW   (PIX_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .quotient (quot),
        .busy     (status.div_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_pend_reg <= 1'b0;
            cen_pend_reg <= 1'b0;
        end
        else
        begin
            acc_pend_reg <= cmd.rd_win;
            cen_pend_reg <= cmd.rd_cen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_q)
        begin
            q_col_reg <= item.col;
            q_row_reg <= item.row;
        end
        if (cmd.clamp)
        begin
            cc_reg   <= XW'(cc_e);
            rc_reg   <= YW'(rc_e);
            wl_reg   <= XW'(wl_e);
            hl_reg   <= YW'(hl_e);
            half_reg <= WSW'(half_e);
        end
        if (cmd.bound)
        begin
            x0_reg       <= XW'(x0_e);
            x1_reg       <= XW'(x1_e);
            y1_reg       <= YW'(y1_e);
            c_reg        <= XW'(x0_e);
            r_reg        <= YW'(y0_e);
            base_reg     <= base_init;
            cen_addr_reg <= cen_addr;
            sum_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cmd.rd_win)
            begin
                if (c_reg == x1_reg)
                begin
                    c_reg    <= x0_reg;
                    r_reg    <= r_reg + YW'(1);
                    base_reg <= base_reg + AW'(MAX_COLS);
                end
                else
                begin
                    c_reg <= c_reg + XW'(1);
                end
            end
            if (acc_pend_reg)
            begin
                sum_reg <= sum_reg + SUMW'(rdata);
                cnt_reg <= cnt_reg + CNTW'(1);
            end
        end
        if (cen_pend_reg)
        begin
            centre_reg <= rdata;
        end
        if (cmd.load_out)
        begin
            result_reg.threshold_out <= thr;
            result_reg.binary_out    <= (centre_reg > thr) ? PIX_MAX : PIX_ZERO;
        end
    end

    always_comb
    begin
        t_s = $signed({3'b000, quot}) - TW'(bias_reg);
        if (t_s < 0)
        begin
            thr = PIX_ZERO;
        end
        else if (t_s > $signed(TW'(PIX_MAX)))
        begin
            thr = PIX_MAX;
        end
        else
        begin
            thr = t_s[PIX_W-1:0];
        end
    end

    assign result = result_reg;

endmodule

FILE: src/amt_checker.sv
// Port-level checker for the adaptive mean threshold block and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module amt_checker import amt_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input amt_item_t   item,
    input logic        result_valid,
    input logic        result_ready,
    input amt_result_t result
);

    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result))
    `ASSERT_IMPLY(a_binary_code, clk, rst_n, result_valid, result.binary_out == PIX_MAX || result.binary_out == PIX_ZERO)
    `ASSERT_IMPLY(a_thr_below_max, clk, rst_n, result_valid && result.binary_out == PIX_MAX, result.threshold_out != PIX_MAX)
    `ASSERT_NEXT(a_query_busy, clk, rst_n, item_valid && item_ready && item.command == CMD_QUERY, !item_ready)
    `ASSERT_NEXT(a_write_no_result, clk, rst_n, item_valid && item_ready && item.command == CMD_WRITE && !result_valid, !result_valid)

endmodule

bind adaptive_mean_threshold_core amt_checker u_amt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
